FILE: src/wwgs_pkg.sv
package wwgs_pkg;

  // Wireworld cell states.
  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_WIRE  = 2'd1,
    CELL_HEAD  = 2'd2,
    CELL_TAIL  = 2'd3
  } cell_t;

  // Action codes carried on in_tuser.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 6'd32;

  // Field widths.
  localparam int IDX_W    = 10;
  localparam int TDATA_W  = 16;
  localparam int ACTION_W = 2;

  // Whether the evaluated cell and each of its neighbors lie inside the active area.
  typedef struct packed {
    logic center_ok;
    logic up_ok;
    logic down_ok;
    logic left_ok;
    logic right_ok;
  } bound_t;

endpackage

FILE: src/wwgs_cell.sv
module wwgs_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic            commit_en,
  input  logic            load_en,
  input  wwgs_pkg::cell_t load_val,
  input  wwgs_pkg::cell_t val_in,
  input  wwgs_pkg::cell_t nxt_in,
  output wwgs_pkg::cell_t val_out,
  output wwgs_pkg::cell_t nxt_out
);

  wwgs_pkg::cell_t val_r;
  wwgs_pkg::cell_t nxt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= wwgs_pkg::CELL_EMPTY;
    end else if (load_en) begin
      val_r <= load_val;
    end else if (commit_en) begin
      val_r <= nxt_r;
    end else if (shift_en) begin
      val_r <= val_in;
    end
  end

  // The next-generation plane needs no reset: every cell gets it written
  // during a step before it is committed.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      nxt_r <= nxt_in;
    end
  end

  assign val_out = val_r;
  assign nxt_out = nxt_r;

endmodule

FILE: src/wwgs_rule.sv
module wwgs_rule (
  input  wwgs_pkg::bound_t        bnd,
  input  wwgs_pkg::cell_t         center,
  // Neighbors from bit 0 up: nw, n, ne, w, e, sw, s, se.
  input  wwgs_pkg::cell_t [7:0]   nbr,
  output wwgs_pkg::cell_t         next_val
);

  logic [7:0] nbr_en;
  logic [3:0] heads;

  assign nbr_en = {bnd.down_ok  & bnd.right_ok,
                   bnd.down_ok,
                   bnd.down_ok  & bnd.left_ok,
                   bnd.right_ok,
                   bnd.left_ok,
                   bnd.up_ok    & bnd.right_ok,
                   bnd.up_ok,
                   bnd.up_ok    & bnd.left_ok};

  always_comb begin
    heads = '0;
    for (int i = 0; i < 8; i++) begin
      heads = heads + 4'(nbr_en[i] && (nbr[i] == wwgs_pkg::CELL_HEAD));
    end
  end

  always_comb begin
    next_val = center;
    if (bnd.center_ok) begin
      unique case (center)
        wwgs_pkg::CELL_EMPTY: next_val = wwgs_pkg::CELL_EMPTY;
        wwgs_pkg::CELL_HEAD:  next_val = wwgs_pkg::CELL_TAIL;
        wwgs_pkg::CELL_TAIL:  next_val = wwgs_pkg::CELL_WIRE;
        wwgs_pkg::CELL_WIRE:  next_val = (heads == 4'd1 || heads == 4'd2) ?
                                         wwgs_pkg::CELL_HEAD : wwgs_pkg::CELL_WIRE;
        default:              next_val = center;
      endcase
    end
  end

endmodule

FILE: src/wireworld_grid_step_core.sv
// Wireworld grid engine.
// The grid of ROWS*COLS cells is held in a ring of small cells that moves one
// place per cycle whenever it rotates; the cell at the head of the ring is the
// access port, and a fixed window of taps around one ring position feeds the
// update rule.
// Input channel (in_*): one item per action. in_tuser selects write cell,
// advance one generation or read cell; in_tdata carries the cell index and
// the value to write. Only a read produces a result item on out_*.
// Write and read: the ring rotates until the addressed cell reaches the head,
// where a write loads the cell and a read samples it. A write beyond the grid
// is dropped; a read beyond it answers zero.
// Step: one full turn of the ring computes the next generation into a second
// plane, then a commit state swaps it in.
// The block works on one item at a time. A read result sits in an output
// register; the next item is accepted while it waits, and a further read
// holds at its last cycle until the receiver has taken the earlier result.
// cfg_* writes rows_in_use and cols_in_use and is always ready.
// Reset clears every cell to empty and sets both registers to 32.
module wireworld_grid_step_core #(
  parameter int ROWS = 32,
  parameter int COLS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [9:0] cell_index, [11:10] cell_value, [15:12] zero
  input  logic [wwgs_pkg::TDATA_W-1:0]         in_tdata,
  // [1:0] action
  input  logic [wwgs_pkg::ACTION_W-1:0]        in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [1:0] read_value, [11:2] read_index, [15:12] zero
  output logic [wwgs_pkg::TDATA_W-1:0]         out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wwgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wwgs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int N   = ROWS * COLS;
  localparam int HW  = $clog2(N);
  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS);
  localparam int RXW = ($clog2(ROWS + 1) > wwgs_pkg::CFG_DATA_W) ?
                       $clog2(ROWS + 1) : wwgs_pkg::CFG_DATA_W;
  localparam int CXW = ($clog2(COLS + 1) > wwgs_pkg::CFG_DATA_W) ?
                       $clog2(COLS + 1) : wwgs_pkg::CFG_DATA_W;
  localparam int AXW = ((HW > wwgs_pkg::IDX_W) ? HW : wwgs_pkg::IDX_W) + 1;

  localparam logic [HW-1:0] H_LAST = HW'(N - 1);
  localparam logic [RW-1:0] R_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] C_LAST = CW'(COLS - 1);

  // Ring positions of the update window. The evaluated cell sits at P_C and
  // moves to P_NXT on the next shift, carrying its new value with it.
  localparam int P_NW  = 0;
  localparam int P_N   = 1;
  localparam int P_NE  = 2;
  localparam int P_W   = COLS;
  localparam int P_C   = COLS + 1;
  localparam int P_E   = (COLS + 2) % N;
  localparam int P_SW  = (2 * COLS) % N;
  localparam int P_S   = (2 * COLS + 1) % N;
  localparam int P_SE  = (2 * COLS + 2) % N;
  localparam int P_NXT = COLS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_STEP,
    ST_COMMIT
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            is_read_r, is_read_nxt;
  logic                            oob_r, oob_nxt;
  logic [wwgs_pkg::IDX_W-1:0]      addr_r, addr_nxt;
  wwgs_pkg::cell_t                 wval_r, wval_nxt;
  logic [HW-1:0]                   head_r, head_nxt;
  logic [HW-1:0]                   cnt_r, cnt_nxt;
  logic [RW-1:0]                   crow_r, crow_nxt;
  logic [CW-1:0]                   ccol_r, ccol_nxt;
  logic [wwgs_pkg::CFG_DATA_W-1:0] rows_r, cols_r;
  logic                            out_valid_r, out_valid_nxt;
  wwgs_pkg::cell_t                 out_val_r, out_val_nxt;
  logic [wwgs_pkg::IDX_W-1:0]      out_idx_r, out_idx_nxt;

  logic                            shift_en;
  logic                            commit_en;
  logic                            load_en;
  logic                            in_range;
  logic                            hit;
  logic [wwgs_pkg::IDX_W-1:0]      in_idx;
  wwgs_pkg::cell_t                 in_val;

  wwgs_pkg::cell_t                 val_w [N];
  wwgs_pkg::cell_t                 nxt_w [N];
  wwgs_pkg::cell_t [7:0]           nbr;
  wwgs_pkg::bound_t                bnd;
  wwgs_pkg::cell_t                 rule_val;

  assign in_idx    = in_tdata[wwgs_pkg::IDX_W-1:0];
  assign in_val    = wwgs_pkg::cell_t'(in_tdata[wwgs_pkg::IDX_W+1:wwgs_pkg::IDX_W]);
  assign in_range  = AXW'(in_idx) < AXW'(N);
  assign hit       = AXW'(head_r) == AXW'(addr_r);
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // The ring: each cell takes its successor's contents on a shift.
  for (genvar k = 0; k < N; k++) begin : g_ring
    localparam int SUCC = (k + 1) % N;
    logic            ld;
    wwgs_pkg::cell_t nxt_src;

    assign ld      = (k == 0) ? load_en : 1'b0;
    assign nxt_src = (k == P_NXT) ? rule_val : nxt_w[SUCC];

    wwgs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (shift_en),
      .commit_en (commit_en),
      .load_en   (ld),
      .load_val  (wval_r),
      .val_in    (val_w[SUCC]),
      .nxt_in    (nxt_src),
      .val_out   (val_w[k]),
      .nxt_out   (nxt_w[k])
    );
  end

  assign nbr = {val_w[P_SE], val_w[P_S], val_w[P_SW], val_w[P_E],
                val_w[P_W], val_w[P_NE], val_w[P_N], val_w[P_NW]};

  always_comb begin
    bnd.center_ok = (RXW'(crow_r) < RXW'(rows_r)) && (CXW'(ccol_r) < CXW'(cols_r));
    bnd.up_ok     = (crow_r != '0);
    bnd.left_ok   = (ccol_r != '0);
    bnd.down_ok   = (crow_r != R_LAST) && (RXW'(crow_r) + RXW'(1) < RXW'(rows_r));
    bnd.right_ok  = (ccol_r != C_LAST) && (CXW'(ccol_r) + CXW'(1) < CXW'(cols_r));
  end

  wwgs_rule u_rule (
    .bnd      (bnd),
    .center   (val_w[P_C]),
    .nbr      (nbr),
    .next_val (rule_val)
  );

  always_comb begin
    state_nxt     = state_r;
    is_read_nxt   = is_read_r;
    oob_nxt       = oob_r;
    addr_nxt      = addr_r;
    wval_nxt      = wval_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_idx_nxt   = out_idx_r;
    shift_en      = 1'b0;
    commit_en     = 1'b0;
    load_en       = 1'b0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          addr_nxt    = in_idx;
          wval_nxt    = in_val;
          oob_nxt     = !in_range;
          is_read_nxt = (in_tuser == wwgs_pkg::ACT_READ);
          cnt_nxt     = '0;
          if (in_tuser == wwgs_pkg::ACT_WRITE) begin
            if (in_range) begin
              state_nxt = ST_SEEK;
            end
          end else if (in_tuser == wwgs_pkg::ACT_STEP) begin
            state_nxt = ST_STEP;
          end else if (in_tuser == wwgs_pkg::ACT_READ) begin
            state_nxt = ST_SEEK;
          end
        end
      end
      ST_SEEK: begin
        if (oob_r || hit) begin
          if (is_read_r) begin
            if (!out_valid_r || out_tready) begin
              out_valid_nxt = 1'b1;
              out_val_nxt   = oob_r ? wwgs_pkg::CELL_EMPTY : val_w[0];
              out_idx_nxt   = addr_r;
              state_nxt     = ST_IDLE;
            end
          end else begin
            load_en   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          shift_en = 1'b1;
        end
      end
      ST_STEP: begin
        shift_en = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == H_LAST) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        commit_en = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Position trackers follow the ring: the head index and the grid
    // coordinates of the cell in the evaluation slot.
    head_nxt = head_r;
    crow_nxt = crow_r;
    ccol_nxt = ccol_r;
    if (shift_en) begin
      head_nxt = (head_r == H_LAST) ? '0 : head_r + 1'b1;
      if (ccol_r == C_LAST) begin
        ccol_nxt = '0;
        crow_nxt = (crow_r == R_LAST) ? '0 : crow_r + 1'b1;
      end else begin
        ccol_nxt = ccol_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      crow_r      <= RW'(1);
      ccol_r      <= CW'(1);
      rows_r      <= wwgs_pkg::DIM_RESET;
      cols_r      <= wwgs_pkg::DIM_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      is_read_r   <= 1'b0;
      oob_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      crow_r      <= crow_nxt;
      ccol_r      <= ccol_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      is_read_r   <= is_read_nxt;
      oob_r       <= oob_nxt;
      if (cfg_valid) begin
        if (cfg_index == wwgs_pkg::REG_ROWS) begin
          rows_r <= cfg_data;
        end else if (cfg_index == wwgs_pkg::REG_COLS) begin
          cols_r <= cfg_data;
        end
      end
    end
    addr_r    <= addr_nxt;
    wval_r    <= wval_nxt;
    out_val_r <= out_val_nxt;
    out_idx_r <= out_idx_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(wwgs_pkg::TDATA_W - wwgs_pkg::IDX_W - 2){1'b0}},
                       out_idx_r, out_val_r};

endmodule

FILE: src/wwgs_checker.sv
module wwgs_checker #(
  parameter int ROWS = 32,
  parameter int COLS = 32
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [wwgs_pkg::ACTION_W-1:0]    in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wwgs_pkg::TDATA_W-1:0]     out_tdata
);

  localparam int N = ROWS * COLS;

  // A result waiting for the receiver holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or vanished while stalled");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A step occupies the block for a full turn of the ring; this checks that it is busy as the step starts.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == wwgs_pkg::ACT_STEP |=> !in_tready)
    else $error("item accepted right after a step");

  // Writes and steps never produce a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid &&
    (in_tuser == wwgs_pkg::ACT_WRITE || in_tuser == wwgs_pkg::ACT_STEP)
    |=> !out_tvalid)
    else $error("result appeared after a write or step");

  // A read beyond the grid answers an empty cell.
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (int'(out_tdata[wwgs_pkg::IDX_W+1:2]) >= N)
    |-> out_tdata[1:0] == wwgs_pkg::CELL_EMPTY)
    else $error("out-of-grid read returned a nonzero cell");

endmodule

bind wireworld_grid_step_core wwgs_checker #(.ROWS(ROWS), .COLS(COLS)) u_wwgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
